// File: sv/wsfp_pkg.sv
package wsfp_pkg;

   localparam int DataWidth    = 8;
   localparam int LenWidth     = 63;
   localparam int AccWidth     = 64;
   localparam int HdrLenWidth  = 4;
   localparam int LenCodeWidth = 7;

   localparam logic [LenWidth-1:0] MaxPayloadReset = LenWidth'(65536);

   localparam logic [DataWidth-1:0]    ReservedMask  = 8'h70;
   localparam logic [LenCodeWidth-1:0] LenCode16     = 7'd126;
   localparam logic [LenCodeWidth-1:0] LenCode64     = 7'd127;
   localparam logic [AccWidth-1:0]     ControlMaxLen = 64'd125;
   localparam logic [HdrLenWidth-1:0]  HdrLen16      = 4'd4;
   localparam logic [HdrLenWidth-1:0]  HdrLen64      = 4'd10;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   localparam logic ErrProtocol = 1'b0;
   localparam logic ErrTooLarge = 1'b1;

   typedef enum logic [4:0] {
      PH_FIRST   = 5'b00001,
      PH_SECOND  = 5'b00010,
      PH_EXT     = 5'b00100,
      PH_PAYLOAD = 5'b01000,
      PH_DROP    = 5'b10000
   } phase_type;

   typedef struct packed {
      kind_type                kind;
      logic [3:0]              opcode;
      logic                    fin;
      logic [LenWidth-1:0]     body_len;
      logic [HdrLenWidth-1:0]  hdr_size;
      logic [DataWidth-1:0]    payload_byte;
      logic                    last;
      logic                    error_code;
   } result_type;

endpackage

// File: sv/wsfp_parser.sv
module wsfp_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [wsfp_pkg::DataWidth-1:0]    req_data_byte,
   input  logic                              req_restart,
   input  logic                              csr_wr_en,
   input  logic [wsfp_pkg::LenWidth-1:0]     csr_wr_data,
   input  logic                              res_ready,
   output logic                              res_valid,
   output wsfp_pkg::result_type              res_data
);
   import wsfp_pkg::*;

   logic                       in_valid_ff;
   logic [DataWidth-1:0]       in_byte_ff;
   logic                       in_restart_ff;
   logic                       step;

   logic [LenWidth-1:0]        max_payload_ff;
   phase_type                  phase_ff, phase_in, phase_eff;
   logic [HdrLenWidth-1:0]     hdr_pos_ff, hdr_pos_in;
   logic [DataWidth-1:0]       first_byte_ff, first_byte_in;
   logic [LenCodeWidth-1:0]    len_code_ff, len_code_in;
   logic [AccWidth-1:0]        len_acc_ff, len_acc_in;
   logic [LenWidth-1:0]        remaining_ff, remaining_in;

   logic [AccWidth-1:0]        acc_shift;
   logic [HdrLenWidth-1:0]     pos_inc;
   logic [HdrLenWidth-1:0]     hdr_total;
   logic [AccWidth-1:0]        len_sel;
   logic                       ctrl_bad;
   logic                       too_big;
   logic                       have_result;
   result_type                 result;
   result_type                 err_proto;
   result_type                 err_large;
   result_type                 header_res;

   assign step      = in_valid_ff && res_ready;
   assign req_stall = in_valid_ff && !res_ready;
   assign res_valid = step && have_result;
   assign res_data  = result;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_byte_ff    <= req_data_byte;
         in_restart_ff <= req_restart;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MaxPayloadReset;
      end else if (csr_wr_en) begin
         max_payload_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FIRST;
         hdr_pos_ff    <= '0;
         first_byte_ff <= '0;
         len_code_ff   <= '0;
         len_acc_ff    <= '0;
         remaining_ff  <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         hdr_pos_ff    <= hdr_pos_in;
         first_byte_ff <= first_byte_in;
         len_code_ff   <= len_code_in;
         len_acc_ff    <= len_acc_in;
         remaining_ff  <= remaining_in;
      end
   end

   assign phase_eff = in_restart_ff ? PH_FIRST : phase_ff;
   assign acc_shift = {len_acc_ff[AccWidth-DataWidth-1:0], in_byte_ff};
   assign pos_inc   = hdr_pos_ff + 4'd1;
   assign hdr_total = (len_code_ff == LenCode16) ? HdrLen16 : HdrLen64;
   assign len_sel   = (phase_eff == PH_SECOND) ?
                      {{(AccWidth-LenCodeWidth){1'b0}}, in_byte_ff[LenCodeWidth-1:0]} :
                      acc_shift;
   assign ctrl_bad  = first_byte_ff[3] && ((len_sel > ControlMaxLen) || !first_byte_ff[7]);
   assign too_big   = len_sel > {1'b0, max_payload_ff};

   always_comb begin
      err_proto            = '0;
      err_proto.kind       = KIND_ERROR;
      err_proto.error_code = ErrProtocol;
      err_large            = '0;
      err_large.kind       = KIND_ERROR;
      err_large.error_code = ErrTooLarge;
      header_res          = '0;
      header_res.kind     = KIND_HEADER;
      header_res.opcode   = first_byte_ff[3:0];
      header_res.fin      = first_byte_ff[7];
      header_res.body_len = len_sel[LenWidth-1:0];
      header_res.last     = (len_sel == '0);
   end

   always_comb begin
      phase_in      = phase_eff;
      hdr_pos_in    = hdr_pos_ff;
      first_byte_in = first_byte_ff;
      len_code_in   = len_code_ff;
      len_acc_in    = len_acc_ff;
      remaining_in  = remaining_ff;
      have_result   = 1'b0;
      result        = '0;
      unique case (phase_eff)
         PH_FIRST: begin
            first_byte_in = in_byte_ff;
            hdr_pos_in    = 4'd1;
            len_code_in   = '0;
            len_acc_in    = '0;
            remaining_in  = '0;
            if ((in_byte_ff & ReservedMask) != '0) begin
               phase_in    = PH_DROP;
               have_result = 1'b1;
               result      = err_proto;
            end else begin
               phase_in = PH_SECOND;
            end
         end
         PH_SECOND: begin
            hdr_pos_in = 4'd2;
            if (in_byte_ff[7]) begin
               phase_in    = PH_DROP;
               have_result = 1'b1;
               result      = err_proto;
            end else begin
               len_code_in = in_byte_ff[LenCodeWidth-1:0];
               if (in_byte_ff[LenCodeWidth-1:0] == LenCode16 ||
                   in_byte_ff[LenCodeWidth-1:0] == LenCode64) begin
                  len_acc_in = '0;
                  phase_in   = PH_EXT;
               end else begin
                  have_result = 1'b1;
                  if (ctrl_bad) begin
                     phase_in = PH_DROP;
                     result   = err_proto;
                  end else if (too_big) begin
                     phase_in = PH_DROP;
                     result   = err_large;
                  end else begin
                     remaining_in    = len_sel[LenWidth-1:0];
                     phase_in        = (len_sel == '0) ? PH_FIRST : PH_PAYLOAD;
                     result          = header_res;
                     result.hdr_size = 4'd2;
                  end
               end
            end
         end
         PH_EXT: begin
            len_acc_in = acc_shift;
            hdr_pos_in = pos_inc;
            if (pos_inc >= hdr_total) begin
               have_result = 1'b1;
               if ((len_code_ff == LenCode64 && acc_shift[AccWidth-1]) || ctrl_bad) begin
                  phase_in = PH_DROP;
                  result   = err_proto;
               end else if (too_big) begin
                  phase_in = PH_DROP;
                  result   = err_large;
               end else begin
                  remaining_in    = len_sel[LenWidth-1:0];
                  phase_in        = (len_sel == '0) ? PH_FIRST : PH_PAYLOAD;
                  result          = header_res;
                  result.hdr_size = pos_inc;
               end
            end
         end
         PH_PAYLOAD: begin
            have_result         = 1'b1;
            result.kind         = KIND_PAYLOAD;
            result.opcode       = first_byte_ff[3:0];
            result.fin          = first_byte_ff[7];
            result.payload_byte = in_byte_ff;
            result.last         = (remaining_ff <= LenWidth'(1));
            if (remaining_ff != '0) begin
               remaining_in = remaining_ff - LenWidth'(1);
            end
            if (remaining_ff <= LenWidth'(1)) begin
               phase_in = PH_FIRST;
            end
         end
         PH_DROP: begin
            phase_in = PH_DROP;
         end
         default: begin
            phase_in = PH_DROP;
         end
      endcase
   end

endmodule

// File: sv/wsfp_out_reg.sv
module wsfp_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  res_valid,
   input  wsfp_pkg::result_type  res_data,
   output logic                  res_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output wsfp_pkg::result_type  rsp_data
);
   import wsfp_pkg::*;

   logic       out_valid_ff;
   result_type out_data_ff;

   assign res_ready = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (res_ready) begin
         out_valid_ff <= res_valid;
      end
      if (res_ready && res_valid) begin
         out_data_ff <= res_data;
      end
   end

endmodule

// File: sv/websocket_server_frame_parser_core.sv
// Receive-side WebSocket frame parser that takes one stream byte per transaction and
// sustains one byte per clock cycle while the output does not stall; each byte passes
// through an input register, combinational header and length decode, and a result
// register, from which its result is presented. A byte yields at most one
// result: a header item when the header is complete, one item per payload byte with
// the final byte flagged, or an error item, after which bytes are dropped until a
// transaction with restart set starts a new frame. The maximum payload register may
// be written only while the parser is idle.
module websocket_server_frame_parser_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [wsfp_pkg::DataWidth-1:0]  req_data_byte,
   input  logic                            req_restart,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_kind,
   output logic [3:0]                      rsp_opcode,
   output logic                            rsp_fin,
   output logic [wsfp_pkg::LenWidth-1:0]   rsp_body_len,
   output logic [wsfp_pkg::HdrLenWidth-1:0] rsp_hdr_size,
   output logic [wsfp_pkg::DataWidth-1:0]  rsp_payload_byte,
   output logic                            rsp_last,
   output logic                            rsp_error_code,
   input  logic                            csr_wr_en,
   input  logic [wsfp_pkg::LenWidth-1:0]   csr_wr_data
);
   import wsfp_pkg::*;

   logic       res_valid;
   logic       res_ready;
   result_type res_data;
   result_type rsp_data;

   wsfp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_restart   (req_restart),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .res_ready     (res_ready),
      .res_valid     (res_valid),
      .res_data      (res_data)
   );

   wsfp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_ready (res_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind         = rsp_data.kind;
   assign rsp_opcode       = rsp_data.opcode;
   assign rsp_fin          = rsp_data.fin;
   assign rsp_body_len     = rsp_data.body_len;
   assign rsp_hdr_size     = rsp_data.hdr_size;
   assign rsp_payload_byte = rsp_data.payload_byte;
   assign rsp_last         = rsp_data.last;
   assign rsp_error_code   = rsp_data.error_code;

endmodule
